>>> src/gds_pkg.sv
`timescale 1ns / 1ps
package gds_pkg;

  localparam int YearWidth  = 14;
  localparam int MonthWidth = 4;
  localparam int DayWidth   = 5;
  localparam int StepWidth  = 16;
  localparam int CountWidth = StepWidth + 1;
  localparam int ResWidth   = 5;

  localparam logic [YearWidth-1:0] YearLimit = 14'd9999;
  localparam logic [ResWidth-1:0]  ResLast   = 5'd24;

  // floor(y / 25) = (y * 5243) >> 17, exact for every 14-bit year
  localparam int                 MulWidth  = 13;
  localparam logic [MulWidth-1:0] DivMul   = 13'd5243;
  localparam int                 DivShift  = 17;
  localparam int                 ProdWidth = YearWidth + MulWidth;
  localparam int                 QWidth    = ProdWidth - DivShift;
  localparam logic [4:0]         Div25     = 5'd25;

  localparam logic [MonthWidth-1:0] MonthFirst = 4'd1;
  localparam logic [MonthWidth-1:0] MonthLast  = 4'd12;
  localparam logic [DayWidth-1:0]   DayFirst   = 5'd1;
  localparam logic [DayWidth-1:0]   DayLast    = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FWD,
    CMD_BACK
  } date_cmd_t;

  typedef struct packed {
    date_cmd_t             cmd;
    logic [YearWidth-1:0]  year;
    logic [MonthWidth-1:0] month;
    logic [DayWidth-1:0]   day;
    logic [ResWidth-1:0]   res25;
  } date_ctl_t;

  typedef struct packed {
    logic [YearWidth-1:0]  year;
    logic [MonthWidth-1:0] month;
    logic [DayWidth-1:0]   day;
    logic                  fwd_end;
    logic                  back_end;
  } date_sts_t;

  // leap: (y%4==0 && y%100!=0) || y%400==0, from y mod 16 and y mod 25
  function automatic logic leap_year(logic [3:0] ylow, logic [ResWidth-1:0] res25);
    leap_year = ((ylow[1:0] == 2'd0) && (res25 != '0)) ||
                ((ylow == 4'd0) && (res25 == '0));
  endfunction

  function automatic logic [DayWidth-1:0] month_len(logic [MonthWidth-1:0] m, logic leap);
    logic [DayWidth-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

>>> src/gds_date_unit.sv
`timescale 1ns / 1ps
module gds_date_unit (
  input  logic                clk,
  input  logic                rst,
  input  gds_pkg::date_ctl_t  ctl,
  output gds_pkg::date_sts_t  sts
);

  logic [gds_pkg::YearWidth-1:0]  year,  year_next;
  logic [gds_pkg::MonthWidth-1:0] month, month_next;
  logic [gds_pkg::DayWidth-1:0]   day,   day_next;
  logic [gds_pkg::ResWidth-1:0]   res25, res25_next;
  logic                           leap;
  logic                           leap_prev;
  logic [gds_pkg::DayWidth-1:0]   len;
  logic [gds_pkg::MonthWidth-1:0] month_dec;

  assign leap      = gds_pkg::leap_year(year[3:0], res25);
  assign leap_prev = leap;
  assign len       = gds_pkg::month_len(month, leap);
  assign month_dec = month - 4'd1;

  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    res25_next = res25;
    case (ctl.cmd)
      gds_pkg::CMD_LOAD: begin
        year_next  = ctl.year;
        month_next = ctl.month;
        day_next   = ctl.day;
        res25_next = ctl.res25;
      end
      gds_pkg::CMD_FWD: begin
        if (day < len) begin
          day_next = day + 5'd1;
        end else if (month < gds_pkg::MonthLast) begin
          month_next = month + 4'd1;
          day_next   = gds_pkg::DayFirst;
        end else begin
          year_next  = year + 14'd1;
          month_next = gds_pkg::MonthFirst;
          day_next   = gds_pkg::DayFirst;
          res25_next = (res25 == gds_pkg::ResLast) ? '0 : res25 + 5'd1;
        end
      end
      gds_pkg::CMD_BACK: begin
        if (day > gds_pkg::DayFirst) begin
          day_next = day - 5'd1;
        end else if (month > gds_pkg::MonthFirst) begin
          month_next = month_dec;
          day_next   = gds_pkg::month_len(month_dec, leap_prev);
        end else begin
          year_next  = year - 14'd1;
          month_next = gds_pkg::MonthLast;
          day_next   = gds_pkg::DayLast;
          res25_next = (res25 == '0) ? gds_pkg::ResLast : res25 - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= '0;
      month <= gds_pkg::MonthFirst;
      day   <= gds_pkg::DayFirst;
      res25 <= '0;
    end else begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      res25 <= res25_next;
    end
  end

  assign sts.year     = year;
  assign sts.month    = month;
  assign sts.day      = day;
  assign sts.fwd_end  = (day == len) && (month == gds_pkg::MonthLast) &&
                        (year >= gds_pkg::YearLimit);
  assign sts.back_end = (day == gds_pkg::DayFirst) && (month == gds_pkg::MonthFirst) &&
                        (year == '0);

endmodule

>>> src/gds_seq.sv
`timescale 1ns / 1ps
module gds_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [gds_pkg::YearWidth-1:0]        new_year,
  input  logic [gds_pkg::MonthWidth-1:0]       new_month,
  input  logic [gds_pkg::DayWidth-1:0]         new_day,
  input  logic signed [gds_pkg::StepWidth-1:0] day_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 ok,
  output logic [gds_pkg::YearWidth-1:0]        cur_year,
  output logic [gds_pkg::MonthWidth-1:0]       cur_month,
  output logic [gds_pkg::DayWidth-1:0]         cur_day,
  output gds_pkg::date_ctl_t                   ctl,
  input  gds_pkg::date_sts_t                   sts
);

  gds_pkg::state_t state, state_next;

  logic [gds_pkg::YearWidth-1:0]  y;
  logic [gds_pkg::MonthWidth-1:0] m;
  logic [gds_pkg::DayWidth-1:0]   d;
  logic                           back;
  logic [gds_pkg::CountWidth-1:0] cnt;
  logic [gds_pkg::CountWidth-1:0] mag;
  logic [gds_pkg::QWidth-1:0]     q;
  logic [gds_pkg::ProdWidth-1:0]  prod;
  logic [gds_pkg::YearWidth:0]    rem_full;
  logic [gds_pkg::ResWidth-1:0]   r25;
  logic                           set_ok;
  logic                           res_ok, res_ok_next;
  logic                           accept;
  logic                           emit;

  assign accept = in_valid && in_ready;
  assign mag    = day_count[gds_pkg::StepWidth-1]
                ? (gds_pkg::CountWidth'(0) - {day_count[gds_pkg::StepWidth-1], day_count})
                : {1'b0, day_count};

  assign prod     = {{gds_pkg::MulWidth{1'b0}}, y} * {{gds_pkg::YearWidth{1'b0}}, gds_pkg::DivMul};
  assign rem_full = {1'b0, y} - ({{(gds_pkg::YearWidth + 1 - gds_pkg::QWidth){1'b0}}, q} *
                    {{(gds_pkg::YearWidth - 4){1'b0}}, gds_pkg::Div25});
  assign r25      = rem_full[gds_pkg::ResWidth-1:0];
  assign set_ok   = (y <= gds_pkg::YearLimit) && (m >= gds_pkg::MonthFirst) &&
                    (m <= gds_pkg::MonthLast) && (d >= gds_pkg::DayFirst) &&
                    (d <= gds_pkg::month_len(m, gds_pkg::leap_year(y[3:0], r25)));

  always_comb begin
    state_next  = state;
    res_ok_next = res_ok;
    in_ready    = (state == gds_pkg::ST_IDLE);
    emit        = 1'b0;
    ctl.cmd     = gds_pkg::CMD_NONE;
    ctl.year    = y;
    ctl.month   = m;
    ctl.day     = d;
    ctl.res25   = r25;
    case (state)
      gds_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_ok_next = 1'b1;
          state_next  = action ? gds_pkg::ST_STEP : gds_pkg::ST_DIV;
        end
      end
      gds_pkg::ST_DIV: begin
        state_next = gds_pkg::ST_CHK;
      end
      gds_pkg::ST_CHK: begin
        res_ok_next = set_ok;
        if (set_ok) begin
          ctl.cmd = gds_pkg::CMD_LOAD;
        end
        state_next = gds_pkg::ST_DONE;
      end
      gds_pkg::ST_STEP: begin
        if (cnt == '0) begin
          state_next = gds_pkg::ST_DONE;
        end else if (back ? sts.back_end : sts.fwd_end) begin
          res_ok_next = 1'b0;
          state_next  = gds_pkg::ST_DONE;
        end else begin
          ctl.cmd = back ? gds_pkg::CMD_BACK : gds_pkg::CMD_FWD;
        end
      end
      gds_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          state_next = gds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gds_pkg::ST_IDLE;
      out_valid <= 1'b0;
      res_ok    <= 1'b0;
    end else begin
      state  <= state_next;
      res_ok <= res_ok_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y    <= new_year;
      m    <= new_month;
      d    <= new_day;
      back <= day_count[gds_pkg::StepWidth-1];
      cnt  <= mag;
    end else if (ctl.cmd == gds_pkg::CMD_FWD || ctl.cmd == gds_pkg::CMD_BACK) begin
      cnt <= cnt - gds_pkg::CountWidth'(1);
    end
    if (state == gds_pkg::ST_DIV) begin
      q <= prod[gds_pkg::ProdWidth-1:gds_pkg::DivShift];
    end
    if (emit) begin
      ok        <= res_ok;
      cur_year  <= sts.year;
      cur_month <= sts.month;
      cur_day   <= sts.day;
    end
  end

endmodule

>>> src/gregorian_date_stepper.sv
`timescale 1ns / 1ps
// Gregorian date stepper: holds one date (year 0..9999, month, day).
// Input channel in_valid/in_ready carries action, new_year, new_month,
// new_day and day_count. action 0 sets the date if valid; action 1 moves
// it by the signed day_count, one day per cycle.
// Output channel out_valid/out_ready returns one result per input transfer:
// ok and the stored date after the operation.
// A set computes the year residue mod 25 via a reciprocal multiply, then
// checks the date. A step is paced by the one-day update unit; it ends
// early at 0-01-01 or 9999-12-31 with ok low.
// in_ready is high only while no item is in progress and returns in the
// same cycle as out_valid, when the result is loaded, so no new item is
// taken before the last one's result is loaded.
// The next item may be taken while a result still waits in the output
// register. When the receiver stalls, the result holds and a finished item
// waits until the output register frees.
// Reset (rst, synchronous) sets the date to 0-01-01 and drops out_valid.
module gregorian_date_stepper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [gds_pkg::YearWidth-1:0]        new_year,
  input  logic [gds_pkg::MonthWidth-1:0]       new_month,
  input  logic [gds_pkg::DayWidth-1:0]         new_day,
  input  logic signed [gds_pkg::StepWidth-1:0] day_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 ok,
  output logic [gds_pkg::YearWidth-1:0]        cur_year,
  output logic [gds_pkg::MonthWidth-1:0]       cur_month,
  output logic [gds_pkg::DayWidth-1:0]         cur_day
);

  gds_pkg::date_ctl_t ctl;
  gds_pkg::date_sts_t sts;

  gds_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .new_year  (new_year),
    .new_month (new_month),
    .new_day   (new_day),
    .day_count (day_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .cur_year  (cur_year),
    .cur_month (cur_month),
    .cur_day   (cur_day),
    .ctl       (ctl),
    .sts       (sts)
  );

  gds_date_unit u_date (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts)
  );

endmodule

>>> src/gds_checker.sv
`timescale 1ns / 1ps
module gds_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 ok,
  input logic [gds_pkg::YearWidth-1:0]        cur_year,
  input logic [gds_pkg::MonthWidth-1:0]       cur_month,
  input logic [gds_pkg::DayWidth-1:0]         cur_day
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(cur_year) &&
    $stable(cur_month) && $stable(cur_day))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cur_year <= gds_pkg::YearLimit && cur_month >= gds_pkg::MonthFirst &&
    cur_month <= gds_pkg::MonthLast && cur_day >= gds_pkg::DayFirst)
    else $error("result date out of range");

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .ok        (ok),
  .cur_year  (cur_year),
  .cur_month (cur_month),
  .cur_day   (cur_day)
);
